@@ design/http_header_content_length_parser_assert.svh @@
// Assertion macros shared by the parser's RTL files.
`ifndef HTTP_HEADER_CONTENT_LENGTH_PARSER_ASSERT_SVH
`define HTTP_HEADER_CONTENT_LENGTH_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HCLP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define HCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define HCLP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/hclp_pkg.sv @@
`default_nettype none
package hclp_pkg;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;

    localparam logic [4:0] NAME_LEN = 5'd14;
    localparam logic [4:0] POS_MAX  = 5'd31;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        PH_SKIP   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [31:0] content_length;
        logic        length_found;
        logic [7:0]  header_lines;
    } t_result;

    // "Content-Length", one character per position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage
`default_nettype wire

@@ design/hclp_core.sv @@
`default_nettype none
`include "http_header_content_length_parser_assert.svh"
module hclp_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output logic                  o_emit,
    output hclp_pkg::t_result     o_result
);

    logic                    r_in_status, n_in_status;
    logic                    r_colon, n_colon;
    logic                    r_prev_cr, n_prev_cr;
    logic [4:0]              r_pos, n_pos;
    logic                    r_starts_empty, n_starts_empty;
    logic                    r_match, n_match;
    logic                    r_name_ended, n_name_ended;
    hclp_pkg::t_phase        r_phase, n_phase;
    logic                    r_neg, n_neg;
    logic [31:0]             r_acc, n_acc;
    logic [31:0]             r_saved, n_saved;
    logic                    r_found, n_found;
    logic [7:0]              r_count, n_count;

    logic        lf_end;
    logic        is_digit;
    logic [35:0] acc_x10;
    logic [31:0] acc_sat;
    logic [31:0] value_res;

    assign lf_end   = (i_byte == hclp_pkg::CH_LF) && r_prev_cr;
    assign o_emit   = lf_end && (r_starts_empty || r_pos == 5'd1);
    assign is_digit = (i_byte >= hclp_pkg::CH_ZERO) && (i_byte <= hclp_pkg::CH_NINE);

    // acc * 10 + digit as two shifted adds; magnitude clamps at 2^31
    assign acc_x10 = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {32'd0, i_byte[3:0]};
    assign acc_sat = (acc_x10 > {4'd0, hclp_pkg::MAG_LIMIT}) ? hclp_pkg::MAG_LIMIT
                                                              : acc_x10[31:0];
    assign value_res = r_neg ? (32'd0 - r_acc)
                     : ((r_acc > hclp_pkg::POS_LIMIT) ? hclp_pkg::POS_LIMIT : r_acc);

    assign o_result.content_length = r_saved;
    assign o_result.length_found   = r_found;
    assign o_result.header_lines   = r_count;

    always_comb begin
        n_in_status    = r_in_status;
        n_colon        = r_colon;
        n_prev_cr      = r_prev_cr;
        n_pos          = r_pos;
        n_starts_empty = r_starts_empty;
        n_match        = r_match;
        n_name_ended   = r_name_ended;
        n_phase        = r_phase;
        n_neg          = r_neg;
        n_acc          = r_acc;
        n_saved        = r_saved;
        n_found        = r_found;
        n_count        = r_count;

        if (lf_end) begin
            if (o_emit) begin
                n_in_status = 1'b1;
                n_saved     = '0;
                n_found     = 1'b0;
                n_count     = '0;
            end else begin
                if (!r_in_status) begin
                    if (r_count != 8'hFF) begin
                        n_count = r_count + 8'd1;
                    end
                    if (r_colon && r_match) begin
                        n_saved = value_res;
                        n_found = 1'b1;
                    end
                end
                n_in_status = 1'b0;
            end
            n_prev_cr      = 1'b0;
            n_colon        = 1'b0;
            n_pos          = '0;
            n_starts_empty = 1'b0;
            n_match        = 1'b1;
            n_name_ended   = 1'b0;
            n_phase        = hclp_pkg::PH_SKIP;
            n_neg          = 1'b0;
            n_acc          = '0;
        end else begin
            if (r_pos == 5'd0 && (i_byte == hclp_pkg::CH_COLON || i_byte == hclp_pkg::CH_NUL)) begin
                n_starts_empty = 1'b1;
            end

            if (!r_colon && i_byte == hclp_pkg::CH_COLON) begin
                n_colon = 1'b1;
                if (!r_name_ended) begin
                    n_name_ended = 1'b1;
                    if (r_pos != hclp_pkg::NAME_LEN) begin
                        n_match = 1'b0;
                    end
                end
            end else if (r_colon) begin
                if (r_phase != hclp_pkg::PH_DONE) begin
                    if (is_digit) begin
                        n_acc   = acc_sat;
                        n_phase = hclp_pkg::PH_DIGITS;
                    end else if (r_phase == hclp_pkg::PH_SKIP && hclp_pkg::is_ws(i_byte)) begin
                        n_phase = hclp_pkg::PH_SKIP;
                    end else if (r_phase == hclp_pkg::PH_SKIP &&
                                 (i_byte == hclp_pkg::CH_PLUS || i_byte == hclp_pkg::CH_MINUS)) begin
                        n_neg   = (i_byte == hclp_pkg::CH_MINUS);
                        n_phase = hclp_pkg::PH_SIGN;
                    end else begin
                        n_phase = hclp_pkg::PH_DONE;
                    end
                end
            end else if (!r_name_ended) begin
                if (i_byte == hclp_pkg::CH_NUL) begin
                    n_name_ended = 1'b1;
                    if (r_pos != hclp_pkg::NAME_LEN) begin
                        n_match = 1'b0;
                    end
                end else if (r_pos >= hclp_pkg::NAME_LEN ||
                             i_byte != hclp_pkg::name_char(r_pos[3:0])) begin
                    n_match = 1'b0;
                end
            end

            if (r_pos != hclp_pkg::POS_MAX) begin
                n_pos = r_pos + 5'd1;
            end
            n_prev_cr = (i_byte == hclp_pkg::CH_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_status    <= 1'b1;
            r_colon        <= 1'b0;
            r_prev_cr      <= 1'b0;
            r_pos          <= '0;
            r_starts_empty <= 1'b0;
            r_match        <= 1'b1;
            r_name_ended   <= 1'b0;
            r_phase        <= hclp_pkg::PH_SKIP;
            r_neg          <= 1'b0;
            r_acc          <= '0;
            r_saved        <= '0;
            r_found        <= 1'b0;
            r_count        <= '0;
        end else if (i_step) begin
            r_in_status    <= n_in_status;
            r_colon        <= n_colon;
            r_prev_cr      <= n_prev_cr;
            r_pos          <= n_pos;
            r_starts_empty <= n_starts_empty;
            r_match        <= n_match;
            r_name_ended   <= n_name_ended;
            r_phase        <= n_phase;
            r_neg          <= n_neg;
            r_acc          <= n_acc;
            r_saved        <= n_saved;
            r_found        <= n_found;
            r_count        <= n_count;
        end
    end

    // a fresh line has seen no colon
    `HCLP_ASSERT_SAME(a_pos0_no_colon, i_clk, i_rst_n, r_pos == 5'd0, !r_colon)
    // header lines are only counted once the status line is behind us
    `HCLP_ASSERT_SAME(a_count_after_status, i_clk, i_rst_n, r_count != 8'd0, !r_in_status)
    // emitting rearms for a new response
    `HCLP_ASSERT_NEXT(a_emit_rearms, i_clk, i_rst_n, i_step && o_emit,
        r_in_status && r_count == 8'd0 && !r_found)

endmodule
`default_nettype wire

@@ design/http_header_content_length_parser.sv @@
// The LF ending the header is accepted into the input register, then its result
// word is registered in the result register once the result slot is free.
// Throughput: one byte per cycle; a byte is taken while a result waits, unless
// the byte in the input register ends another header, which then holds the input.
// Reset (i_rst_n low, synchronous) clears both handshake stages and rearms
// the parser at the start of a status line.
`default_nettype none
`include "http_header_content_length_parser_assert.svh"
module http_header_content_length_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_content_length,
    output logic             o_length_found,
    output logic [7:0]       o_header_lines
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    hclp_pkg::t_result r_out;

    logic              core_emit;
    hclp_pkg::t_result core_result;
    logic              out_free;
    logic              stage_adv;

    assign out_free  = !r_out_valid || i_ready;
    // a byte that ends the header waits only if the result slot is busy
    assign stage_adv = r_in_valid && (!core_emit || out_free);
    assign o_ready   = !r_in_valid || stage_adv;

    hclp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (stage_adv),
        .i_byte   (r_in_byte),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_content_length = r_out.content_length;
    assign o_length_found   = r_out.length_found;
    assign o_header_lines   = r_out.header_lines;

    // a held byte stays put until the parser takes it
    `HCLP_ASSERT_NEXT(a_hold_input, i_clk, i_rst_n, r_in_valid && !stage_adv,
        r_in_valid && $stable(r_in_byte))
    // every emitted result lands in the output register
    `HCLP_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, stage_adv && core_emit, r_out_valid)
    // an empty input stage never refuses a word
    `HCLP_ASSERT_SAME(a_empty_ready, i_clk, i_rst_n, !r_in_valid, o_ready)

endmodule
`default_nettype wire
